// ----- hw/rtl/pair_histogram_counter_assert.svh -----
// Assertion macros for the pair histogram counter checker.
// Each macro expects a clock named clk and takes the reset as an argument.
`ifndef PAIR_HISTOGRAM_COUNTER_ASSERT_SVH
`define PAIR_HISTOGRAM_COUNTER_ASSERT_SVH

// Overlapping implication, disabled while reset is asserted.
`define PHC_ASSERT_IMP(label, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PHC_ASSERT_NXT(label, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/phc_pkg.sv -----
// Shared types and constants of the pair histogram counter.
// No dependencies; imported by every module of the block except phc_ram.
package phc_pkg;

	// Table geometry
	localparam int MAX_BINS = 128;
	localparam int BIN_W    = $clog2(MAX_BINS);
	localparam int ADDR_W   = 2 * BIN_W;
	localparam int DEPTH    = MAX_BINS * MAX_BINS;

	// Field widths
	localparam int CNT_W  = 32;
	localparam int REG_W  = 8;
	localparam int VAL_W  = 17;
	localparam int FRAC_W = 16;
	localparam int RBIN_W = 7;
	localparam int PROD_W = VAL_W + BIN_W;

	// Fixed-point constants
	localparam logic [VAL_W-1:0]  ONE_FIXED  = VAL_W'(1) << FRAC_W;
	localparam logic [PROD_W-1:0] HALF_FIXED = PROD_W'(1) << (FRAC_W - 1);
	localparam logic [REG_W-1:0]  BINS_RESET = REG_W'(MAX_BINS);

	// Operation codes
	typedef enum logic [1:0] {
		OP_COUNT = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// Configuration register indexes
	typedef enum logic {
		REG_A_BINS = 1'b0,
		REG_B_BINS = 1'b1
	} reg_idx_t;

	// Decoded command for one accepted item
	typedef struct packed {
		logic              do_count;
		logic              do_read;
		logic              do_clear;
		logic [ADDR_W-1:0] addr;
	} cmd_t;

endpackage

// ----- hw/rtl/phc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Self-contained; no package dependency.
module phc_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 14
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, old data on a same-address collision
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/phc_binner.sv -----
// Item decoder: scales a sample pair to its table address, or passes a read address.
// Depends on phc_pkg for widths, op codes and the command struct.
module phc_binner import phc_pkg::*; (
	input  logic [1:0]        op,
	input  logic              active,
	input  logic [VAL_W-1:0]  a_value,
	input  logic [VAL_W-1:0]  b_value,
	input  logic [RBIN_W-1:0] read_a_bin,
	input  logic [RBIN_W-1:0] read_b_bin,
	input  logic [REG_W-1:0]  a_bins,
	input  logic [REG_W-1:0]  b_bins,
	output cmd_t              cmd
);

	logic [BIN_W-1:0]  a_span, b_span;
	logic [VAL_W-1:0]  a_sat, b_sat;
	logic [PROD_W-1:0] a_sum, b_sum;
	logic [BIN_W-1:0]  a_bin, b_bin;

	// bins - 1, with zero taken as one bin and the top clamped to the table
	function automatic logic [BIN_W-1:0] span_of(input logic [REG_W-1:0] bin_cnt);
		logic [BIN_W-1:0] s;
		if (bin_cnt == '0) begin
			s = '0;
		end else if (int'(bin_cnt) > MAX_BINS) begin
			s = BIN_W'(MAX_BINS - 1);
		end else begin
			s = BIN_W'(bin_cnt - REG_W'(1));
		end
		return s;
	endfunction

	// Round half up of value * (bins - 1); result never exceeds bins - 1
	always_comb begin
		a_span = span_of(a_bins);
		b_span = span_of(b_bins);
		a_sat  = (a_value > ONE_FIXED) ? ONE_FIXED : a_value;
		b_sat  = (b_value > ONE_FIXED) ? ONE_FIXED : b_value;
		a_sum  = (PROD_W'(a_sat) * PROD_W'(a_span)) + HALF_FIXED;
		b_sum  = (PROD_W'(b_sat) * PROD_W'(b_span)) + HALF_FIXED;
		a_bin  = a_sum[FRAC_W +: BIN_W];
		b_bin  = b_sum[FRAC_W +: BIN_W];
	end

	// Command decode; read bins always lie inside the table
	always_comb begin
		cmd = '0;
		case (op)
			OP_COUNT: begin
				cmd.do_count = active;
				cmd.addr     = {a_bin, b_bin};
			end
			OP_READ: begin
				cmd.do_read = 1'b1;
				cmd.addr    = {BIN_W'(read_a_bin), BIN_W'(read_b_bin)};
			end
			OP_CLEAR: begin
				cmd.do_read  = 1'b1;
				cmd.do_clear = 1'b1;
				cmd.addr     = {BIN_W'(read_a_bin), BIN_W'(read_b_bin)};
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- hw/rtl/pair_histogram_counter.sv -----
// Two-dimensional histogram: read-modify-write of a 128 x 128 table of 32-bit counters.
// A read result is strobed on done from the result register, after stage 1 (valid_s1 and RAM read data).
// Throughput: one item per cycle while busy is low; one-entry forwarding covers back-to-back same-bin updates.
// The table RAM (one write and one read port) sets that rate; done cannot be stalled.
// Reset: busy stays high for a pass that zeroes the table, one entry per cycle.
// Configuration writes are taken at any time, also during that pass.
module pair_histogram_counter import phc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        op,
	input  logic              active,
	input  logic [VAL_W-1:0]  a_value,
	input  logic [VAL_W-1:0]  b_value,
	input  logic [RBIN_W-1:0] read_a_bin,
	input  logic [RBIN_W-1:0] read_b_bin,
	output logic              done,
	output logic [CNT_W-1:0]  bin_count,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [REG_W-1:0]  cfg_data
);

	logic [REG_W-1:0]  a_bins_q, b_bins_q;
	logic              clr_active_q;
	logic [ADDR_W-1:0] clr_addr_q;
	cmd_t              cmd;
	logic              accept;
	logic              valid_s1;
	cmd_t              cmd_s1;
	logic              fwd_hit_s1;
	logic [CNT_W-1:0]  fwd_data_s1;
	logic [CNT_W-1:0]  rd_data;
	logic [CNT_W-1:0]  cur_count;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [CNT_W-1:0]  wr_data;
	logic              done_q;
	logic [CNT_W-1:0]  bin_count_q;

	assign cfg_ready = 1'b1;
	assign busy      = clr_active_q;
	assign accept    = start && !clr_active_q;
	assign done      = done_q;
	assign bin_count = bin_count_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_bins_q <= BINS_RESET;
			b_bins_q <= BINS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_A_BINS: a_bins_q <= cfg_data;
				REG_B_BINS: b_bins_q <= cfg_data;
				default:    a_bins_q <= a_bins_q;
			endcase
		end
	end

	// Table clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// Address and command decode
	phc_binner u_binner (
		.op         (op),
		.active     (active),
		.a_value    (a_value),
		.b_value    (b_value),
		.read_a_bin (read_a_bin),
		.read_b_bin (read_b_bin),
		.a_bins     (a_bins_q),
		.b_bins     (b_bins_q),
		.cmd        (cmd)
	);

	// Counter table
	phc_ram #(
		.DATA_W (CNT_W),
		.ADDR_W (ADDR_W)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (accept),
		.raddr (cmd.addr),
		.rdata (rd_data)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && (cmd.do_count || cmd.do_read);
		end
	end

	// Stage 1 payload; capture a write that lands on the entry being read
	always_ff @(posedge clk) begin
		cmd_s1      <= cmd;
		fwd_hit_s1  <= wr_en && (wr_addr == cmd.addr);
		fwd_data_s1 <= wr_data;
	end

	assign cur_count = fwd_hit_s1 ? fwd_data_s1 : rd_data;

	// Write-back: clearing pass, saturating increment, or read-and-clear
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cmd_s1.addr;
		wr_data = '0;
		if (clr_active_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
		end else if (valid_s1 && cmd_s1.do_count) begin
			wr_en   = 1'b1;
			wr_data = (cur_count == '1) ? cur_count : cur_count + CNT_W'(1);
		end else if (valid_s1 && cmd_s1.do_clear) begin
			wr_en = 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1 && cmd_s1.do_read;
		end
	end

	always_ff @(posedge clk) begin
		bin_count_q <= cur_count;
	end

endmodule

// ----- hw/rtl/phc_checker.sv -----
// Port-level checker for the pair histogram counter, bound to the top level.
// Depends on phc_pkg and on the assertion macros in pair_histogram_counter_assert.svh.
`include "pair_histogram_counter_assert.svh"

module phc_checker import phc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [1:0]        op,
	input logic [RBIN_W-1:0] read_a_bin,
	input logic [RBIN_W-1:0] read_b_bin,
	input logic              done,
	input logic [CNT_W-1:0]  bin_count,
	input logic              cfg_valid,
	input logic              cfg_ready
);

	logic acc_read;
	logic acc_clear;

	assign acc_read  = start && !busy && (op == OP_READ);
	assign acc_clear = start && !busy && (op == OP_CLEAR);

	// Every read transfer gets its result on done
	`PHC_ASSERT_IMP(a_read_done, arst_n, acc_read || acc_clear, ##2 done, "read result missing")

	// No result without a matching read transfer
	`PHC_ASSERT_IMP(a_done_src, arst_n, done, $past(acc_read || acc_clear, 2), "spurious result")

	// A bin read right after its read-and-clear must show zero (forwarding path)
	`PHC_ASSERT_IMP(a_clr_fwd, arst_n, acc_clear ##1 (acc_read && read_a_bin == $past(read_a_bin) && read_b_bin == $past(read_b_bin)), ##2 (bin_count == '0), "cleared bin not zero")

	// Configuration channel is always ready
	`PHC_ASSERT_NXT(a_cfg_rdy, arst_n, cfg_valid || !cfg_valid, cfg_ready, "cfg_ready dropped")

endmodule

bind pair_histogram_counter phc_checker u_phc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.op         (op),
	.read_a_bin (read_a_bin),
	.read_b_bin (read_b_bin),
	.done       (done),
	.bin_count  (bin_count),
	.cfg_valid  (cfg_valid),
	.cfg_ready  (cfg_ready)
);

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Testbench for pair_histogram_counter: directed and random count, read and clear traffic.
// Depends on phc_pkg and the pair_histogram_counter RTL; holds its own histogram predictor.
module tb;
	import phc_pkg::*;

	// Op code with no operation behind it; the block must ignore it
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Cycles with no transfer at all before the run is declared hung (covers the clear pass)
	localparam int QUIET_LIMIT = 60000;
	// Cycles a count update may still be in flight after the last result
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS = 115;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        op = OP_COUNT;
	logic              active = 1'b0;
	logic [VAL_W-1:0]  a_value = '0;
	logic [VAL_W-1:0]  b_value = '0;
	logic [RBIN_W-1:0] read_a_bin = '0;
	logic [RBIN_W-1:0] read_b_bin = '0;
	logic              done;
	logic [CNT_W-1:0]  bin_count;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              cfg_index = REG_A_BINS;
	logic [REG_W-1:0]  cfg_data = '0;

	// Predictor state: the count table and the bin registers as the block should hold them
	logic [CNT_W-1:0] histogram [DEPTH];
	logic [REG_W-1:0] a_bins_reg = BINS_RESET;
	logic [REG_W-1:0] b_bins_reg = BINS_RESET;
	logic [CNT_W-1:0] pending_counts [$];
	int               mismatches = 0;
	int               quiet_cycles = 0;
	bit               sender_gaps = 1'b1;

	pair_histogram_counter i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.active     (active),
		.a_value    (a_value),
		.b_value    (b_value),
		.read_a_bin (read_a_bin),
		.read_b_bin (read_b_bin),
		.done       (done),
		.bin_count  (bin_count),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #4 clk = ~clk;

	// Bin of one axis value: clip at 1.0, then round-half-up of value*(bins-1)
	function automatic logic [BIN_W-1:0] value_bin(logic [VAL_W-1:0] value,
			logic [REG_W-1:0] bins_reg);
		int unsigned       n_bins;
		longint unsigned   scaled;
		n_bins = (bins_reg == 0) ? 1 : ((bins_reg > MAX_BINS) ? MAX_BINS : bins_reg);
		scaled = (value > ONE_FIXED) ? ONE_FIXED : value;
		scaled = (scaled * (n_bins - 1) + HALF_FIXED) >> FRAC_W;
		if (scaled >= n_bins)
			scaled = n_bins - 1;
		return scaled[BIN_W-1:0];
	endfunction

	// Histogram update for one accepted item; reads queue the count seen before any clear.
	// Read bins are 7 bits wide, so they always fall inside the 128 x 128 table.
	function automatic void histogram_step(logic [1:0] item_op, logic item_active,
			logic [VAL_W-1:0] av, logic [VAL_W-1:0] bv,
			logic [RBIN_W-1:0] ra, logic [RBIN_W-1:0] rb);
		logic [ADDR_W-1:0] addr;
		case (item_op)
			OP_COUNT: begin
				if (item_active) begin
					addr = {value_bin(av, a_bins_reg), value_bin(bv, b_bins_reg)};
					if (histogram[addr] != '1)
						histogram[addr] = histogram[addr] + 1'b1;
				end
			end
			OP_READ, OP_CLEAR: begin
				addr = {ra, rb};
				pending_counts.push_back(histogram[addr]);
				if (item_op == OP_CLEAR)
					histogram[addr] = '0;
			end
			default: ;
		endcase
	endfunction

	// Axis value weighted toward the ends of the range; some above 1.0
	function automatic logic [VAL_W-1:0] random_value();
		case ($urandom_range(9))
			0: return '0;
			1: return ONE_FIXED;
			2: return VAL_W'($urandom);
			default: return VAL_W'($urandom_range(ONE_FIXED));
		endcase
	endfunction

	// Bin register value: out-of-range codes, extremes, and small counts most often
	function automatic logic [REG_W-1:0] random_bins();
		case ($urandom_range(7))
			0: return '0;
			1: return 8'd1;
			2: return '1;
			3: return BINS_RESET;
			4: return REG_W'($urandom);
			default: return REG_W'($urandom_range(12, 2));
		endcase
	endfunction

	// Send one item: optional gap, then hold start until the transfer
	task automatic send_item(input logic [1:0] item_op, input logic item_active,
			input logic [VAL_W-1:0] av, input logic [VAL_W-1:0] bv,
			input logic [RBIN_W-1:0] ra, input logic [RBIN_W-1:0] rb);
		while (sender_gaps && $urandom_range(99) < 17) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		op         <= item_op;
		active     <= item_active;
		a_value    <= av;
		b_value    <= bv;
		read_a_bin <= ra;
		read_b_bin <= rb;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		histogram_step(item_op, item_active, av, bv, ra, rb);
	endtask

	// Stop sending, wait for all results, then let in-flight updates land
	task automatic drain_pipeline(input int extra_cycles);
		start <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (extra_cycles)
			@(posedge clk);
	endtask

	// Register write while the block is idle
	task automatic write_register(input reg_idx_t idx, input logic [REG_W-1:0] value);
		drain_pipeline(SETTLE_CYCLES);
		while ($urandom_range(99) < 17)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_A_BINS)
			a_bins_reg = value;
		else
			b_bins_reg = value;
	endtask

	// Every operation at the extremes of the value range, default bin counts
	task automatic test_operations();
		send_item(OP_COUNT, 1'b1, '0, '0, '0, '0);
		send_item(OP_COUNT, 1'b1, ONE_FIXED, ONE_FIXED, '0, '0);
		send_item(OP_COUNT, 1'b1, '1, 17'd1, '0, '0);
		// inactive sample and unused op change nothing
		send_item(OP_COUNT, 1'b0, '0, '0, '1, '1);
		send_item(OP_UNUSED, 1'b1, '0, '0, '0, '0);
		send_item(OP_READ, 1'b0, '1, '1, 7'd0, 7'd0);
		send_item(OP_CLEAR, 1'b0, '0, '0, 7'd127, 7'd127);
		send_item(OP_READ, 1'b0, '0, '0, 7'd127, 7'd127);
		// active bit does not matter on reads
		send_item(OP_READ, 1'b1, '0, '0, 7'd127, 7'd0);
		send_item(OP_CLEAR, 1'b1, '0, '0, 7'd127, 7'd0);
	endtask

	// Out-of-range register codes and half-bin rounding
	task automatic test_bin_registers();
		write_register(REG_A_BINS, '0);
		write_register(REG_B_BINS, '1);
		send_item(OP_COUNT, 1'b1, ONE_FIXED, 17'd32768, '0, '0);
		send_item(OP_READ, 1'b0, '0, '0, 7'd0, 7'd64);
		write_register(REG_A_BINS, 8'd129);
		write_register(REG_B_BINS, 8'd1);
		send_item(OP_COUNT, 1'b1, ONE_FIXED, ONE_FIXED, '0, '0);
		send_item(OP_CLEAR, 1'b0, '0, '0, 7'd127, 7'd0);
		write_register(REG_A_BINS, 8'd2);
		write_register(REG_B_BINS, 8'd2);
		send_item(OP_COUNT, 1'b1, 17'd32768, 17'd32767, '0, '0);
		send_item(OP_CLEAR, 1'b0, '0, '0, 7'd1, 7'd0);
		// bin outside the configured range is still a plain table entry
		send_item(OP_READ, 1'b0, '0, '0, 7'd64, 7'd64);
	endtask

	// Random phases: new bin counts each phase, reads mostly aimed at counted bins
	task automatic test_random_traffic();
		int               r;
		logic [1:0]       item_op;
		logic             item_active;
		logic [RBIN_W-1:0] ra;
		logic [RBIN_W-1:0] rb;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			// first phase runs back to back at the reset bin counts
			sender_gaps = (phase != 0);
			if (phase == 0) begin
				write_register(REG_A_BINS, BINS_RESET);
				write_register(REG_B_BINS, BINS_RESET);
			end else begin
				write_register(REG_A_BINS, random_bins());
				write_register(REG_B_BINS, random_bins());
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(99);
				item_active = ($urandom_range(9) != 0);
				if (r < 55)
					item_op = OP_COUNT;
				else if (r < 75)
					item_op = OP_READ;
				else if (r < 95)
					item_op = OP_CLEAR;
				else
					item_op = OP_UNUSED;
				if ($urandom_range(9) < 7) begin
					ra = value_bin(random_value(), a_bins_reg);
					rb = value_bin(random_value(), b_bins_reg);
				end else begin
					ra = RBIN_W'($urandom);
					rb = RBIN_W'($urandom);
				end
				send_item(item_op, item_active, random_value(), random_value(), ra, rb);
			end
		end
		sender_gaps = 1'b1;
	endtask

	// Result check against the oldest queued count
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_counts.size() == 0) begin
				$error("bin_count: no result expected, actual %0h", bin_count);
				mismatches++;
			end else begin
				if (bin_count !== pending_counts[0]) begin
					$error("bin_count: expected %0h, actual %0h", pending_counts[0], bin_count);
					mismatches++;
				end
				void'(pending_counts.pop_front());
			end
		end
	end

	// Watchdog: cycles with no item, result or register transfer
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < DEPTH; i++)
			histogram[i] = '0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		test_operations();
		test_bin_registers();
		test_random_traffic();
		drain_pipeline(8);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- pair_histogram_counter.f -----
+incdir+hw/rtl
hw/rtl/phc_pkg.sv
hw/rtl/phc_ram.sv
hw/rtl/phc_binner.sv
hw/rtl/pair_histogram_counter.sv
hw/rtl/phc_checker.sv
test/tb.sv
